/* design/c2d_pkg.sv */
`default_nettype none

package c2d_pkg;

   // Line buffer geometry.
   localparam int MAX_WIDTH  = 1024;
   localparam int IDX_W      = $clog2(MAX_WIDTH);
   localparam int MAX_HEIGHT = 4096;

   // Field widths.
   localparam int PIX_W      = 16;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = PIX_W + COEF_W;
   localparam int CSUM_W     = PROD_W + 2;
   localparam int SUM_W      = 36;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 12;
   localparam int KROW_W     = 48;
   localparam int IW_W       = 11;
   localparam int IH_W       = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MIDDLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd4;

   localparam logic [IW_W-1:0] WIDTH_RESET  = 11'd28;
   localparam logic [IH_W-1:0] HEIGHT_RESET = 13'd28;
   localparam logic [IW_W-1:0] WIDTH_MIN    = 11'd3;
   localparam logic [IW_W-1:0] WIDTH_MAX    = IW_W'(MAX_WIDTH);
   localparam logic [IH_W-1:0] HEIGHT_MIN   = 13'd3;
   localparam logic [IH_W-1:0] HEIGHT_MAX   = IH_W'(MAX_HEIGHT);

   typedef logic signed [PIX_W-1:0]  pix_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [CSUM_W-1:0] csum_type;

   // One window column: index 0 is the top row, index 2 the bottom row.
   typedef logic [2:0][PIX_W-1:0]  pix_col_type;
   typedef logic [2:0][COEF_W-1:0] coef_col_type;

   typedef struct packed {
      logic             take;
      logic             retire;
      logic [IDX_W-1:0] index;
   } lb_ctrl_type;

   typedef struct packed {
      logic en;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* design/c2d_stream_if.sv */
`default_nettype none

interface c2d_req_if;
   import c2d_pkg::*;

   logic    valid;
   logic    ready;
   pix_type pixel;
   logic    frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface c2d_rsp_if;
   import c2d_pkg::*;

   logic             valid;
   logic             ready;
   sum_type          conv_sum;
   logic [COL_W-1:0] out_column;
   logic [ROW_W-1:0] out_row;
   logic             frame_end;

   modport source (output valid, output conv_sum, output out_column, output out_row,
                   output frame_end, input ready);
   modport sink   (input valid, input conv_sum, input out_column, input out_row,
                   input frame_end, output ready);
endinterface

`default_nettype wire

/* design/conv2d_3x3_stream_core.sv */
`default_nettype none

// Streaming 3x3 valid-mode convolution of one image channel.
// Pixels enter on the req channel in raster order, one transaction per
// pixel; frame_start puts a pixel at column 0, row 0. For every pixel whose
// 3x3 neighborhood lies inside the image, one transaction leaves on the rsp
// channel with the exact 36-bit sum, the window center and a frame_end flag
// on the last result of the image. Border pixels produce no result.
// Kernel rows and the image size are set through the csr write port while
// the stream is idle; the size is clamped to 3..1024 columns, 3..4096 rows.
// Throughput is one pixel per clock while the receiver does not stall. A
// result is registered on rsp after line buffer read, window shift,
// multiply, column sum and final sum. The line buffer memories are read and
// written once per transaction, which sets the one-pixel-per-clock rate.
// When the receiver stalls, the whole pipeline holds and req.ready drops
// until the output register is emptied. Reset clears the pipeline, the
// position counters, the window and the configuration (kernel zero,
// 28 x 28 image); the line buffers need no clearing.
module conv2d_3x3_stream_core (
   input  wire                               clock,
   input  wire                               reset,
   c2d_req_if.sink                           req,
   c2d_rsp_if.source                         rsp,
   input  wire                               csr_write_enable,
   input  wire [c2d_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [c2d_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import c2d_pkg::*;

   // Configuration registers.
   logic [KROW_W-1:0] kernel_top_ff;
   logic [KROW_W-1:0] kernel_mid_ff;
   logic [KROW_W-1:0] kernel_bot_ff;
   logic [IW_W-1:0]   width_ff;
   logic [IH_W-1:0]   height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_top_ff <= '0;
         kernel_mid_ff <= '0;
         kernel_bot_ff <= '0;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KERNEL_TOP:    kernel_top_ff <= csr_write_data[KROW_W-1:0];
            CSR_KERNEL_MIDDLE: kernel_mid_ff <= csr_write_data[KROW_W-1:0];
            CSR_KERNEL_BOTTOM: kernel_bot_ff <= csr_write_data[KROW_W-1:0];
            CSR_IMAGE_WIDTH:   width_ff      <= csr_write_data[IW_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff     <= csr_write_data[IH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves as a whole whenever the output register can take
   // a new value.
   logic rsp_valid_ff;
   logic en;
   logic take;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;
   assign take      = req.valid && en;

   // Position of the incoming pixel and the end-of-row and end-of-image tests.
   logic [IW_W-1:0]  width_use;
   logic [IH_W-1:0]  height_use;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_in;
   logic [COL_W-1:0] col_cur;
   logic [ROW_W-1:0] row_cur;
   logic             col_last;
   logic             row_last;
   logic             emit_cur;

   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         width_use = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         width_use = WIDTH_MAX;
      end else begin
         width_use = width_ff;
      end
      if (height_ff < HEIGHT_MIN) begin
         height_use = HEIGHT_MIN;
      end else if (height_ff > HEIGHT_MAX) begin
         height_use = HEIGHT_MAX;
      end else begin
         height_use = height_ff;
      end

      col_cur  = req.frame_start ? '0 : col_ff;
      row_cur  = req.frame_start ? '0 : row_ff;
      col_last = ({1'b0, col_cur} + IW_W'(1)) >= width_use;
      row_last = ({1'b0, row_cur} + IH_W'(1)) >= height_use;
      emit_cur = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));

      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_cur + ROW_W'(1);
      end else begin
         col_in = col_cur + COL_W'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (take) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Result tag that travels alongside the data.
   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             last;
   } tag_type;

   tag_type tag_cur;
   assign tag_cur.column = col_cur - COL_W'(1);
   assign tag_cur.row    = row_cur - ROW_W'(1);
   assign tag_cur.last   = col_last && row_last;

   // Stage 1: line buffer read data is available; every pixel counts here.
   logic    v1_ff;
   logic    e1_ff;
   tag_type tag1_ff;
   pix_type px1_ff;
   // Stages 2 to 4 carry only pixels that produce a result.
   logic    e2_ff;
   logic    e3_ff;
   logic    e4_ff;
   tag_type tag2_ff;
   tag_type tag3_ff;
   tag_type tag4_ff;
   tag_type tag_out_ff;
   sum_type sum_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         e2_ff        <= 1'b0;
         e3_ff        <= 1'b0;
         e4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= take;
         e2_ff        <= v1_ff && e1_ff;
         e3_ff        <= e2_ff;
         e4_ff        <= e3_ff;
         rsp_valid_ff <= e4_ff;
      end
   end

   logic    shift;
   pix_type up1;
   pix_type up2;
   csum_type csum [3];

   assign shift = en && v1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff      <= emit_cur;
         tag1_ff    <= tag_cur;
         px1_ff     <= req.pixel;
         tag2_ff    <= tag1_ff;
         tag3_ff    <= tag2_ff;
         tag4_ff    <= tag3_ff;
         tag_out_ff <= tag4_ff;
         sum_out_ff <= SUM_W'(csum[0]) + SUM_W'(csum[1]) + SUM_W'(csum[2]);
      end
   end

   // Two rows of history: one memory transaction per pixel.
   lb_ctrl_type lb_ctrl;
   assign lb_ctrl.take   = take;
   assign lb_ctrl.retire = shift;
   assign lb_ctrl.index  = col_cur;

   c2d_line_buf u_line_buf (
      .clock    (clock),
      .ctrl     (lb_ctrl),
      .pixel_in (req.pixel),
      .up1      (up1),
      .up2      (up2)
   );

   // Window: three cells, the newest column on the right. Each cell
   // multiplies its column by the matching kernel column.
   cell_ctrl_type cell_ctrl;
   pix_col_type   col_new;
   pix_col_type   col_2to1;
   pix_col_type   col_1to0;
   coef_col_type  coef_col [3];

   assign cell_ctrl.en    = en;
   assign cell_ctrl.shift = shift;
   assign col_new         = {px1_ff, up1, up2};

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         coef_col[j] = {kernel_bot_ff[COEF_W*j +: COEF_W],
                        kernel_mid_ff[COEF_W*j +: COEF_W],
                        kernel_top_ff[COEF_W*j +: COEF_W]};
      end
   end

   c2d_cell u_cell_2 (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cell_ctrl),
      .col_in  (col_new),
      .coef    (coef_col[2]),
      .col_out (col_2to1),
      .csum    (csum[2])
   );

   c2d_cell u_cell_1 (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cell_ctrl),
      .col_in  (col_2to1),
      .coef    (coef_col[1]),
      .col_out (col_1to0),
      .csum    (csum[1])
   );

   c2d_cell u_cell_0 (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cell_ctrl),
      .col_in  (col_1to0),
      .coef    (coef_col[0]),
      .col_out (),
      .csum    (csum[0])
   );

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.conv_sum   = sum_out_ff;
   assign rsp.out_column = tag_out_ff.column;
   assign rsp.out_row    = tag_out_ff.row;
   assign rsp.frame_end  = tag_out_ff.last;

endmodule

`default_nettype wire

/* design/c2d_line_buf.sv */
`default_nettype none

module c2d_line_buf (
   input  wire                   clock,
   input  c2d_pkg::lb_ctrl_type  ctrl,
   input  c2d_pkg::pix_type      pixel_in,
   output c2d_pkg::pix_type      up1,
   output c2d_pkg::pix_type      up2
);
   import c2d_pkg::*;

   // Bank A holds the newest pixel seen at each column, bank B the one before it.
   pix_type          bank_a_mem [MAX_WIDTH];
   pix_type          bank_b_mem [MAX_WIDTH];

   pix_type          a_rd_ff;
   pix_type          b_rd_ff;
   pix_type          fwd_data_ff;
   logic             fwd_ff;
   logic [IDX_W-1:0] idx_ff;

   // Bank B is written back when the item leaves the first stage. When the
   // next transaction reads the same column at that edge, the value being
   // written is forwarded instead of the stale read.
   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         a_rd_ff                <= bank_a_mem[ctrl.index];
         b_rd_ff                <= bank_b_mem[ctrl.index];
         bank_a_mem[ctrl.index] <= pixel_in;
         idx_ff                 <= ctrl.index;
         fwd_ff                 <= ctrl.retire && (ctrl.index == idx_ff);
         fwd_data_ff            <= a_rd_ff;
      end
      if (ctrl.retire) begin
         bank_b_mem[idx_ff] <= a_rd_ff;
      end
   end

   assign up1 = a_rd_ff;
   assign up2 = fwd_ff ? fwd_data_ff : b_rd_ff;

endmodule

`default_nettype wire

/* design/c2d_cell.sv */
`default_nettype none

module c2d_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  c2d_pkg::cell_ctrl_type  ctrl,
   input  c2d_pkg::pix_col_type    col_in,
   input  c2d_pkg::coef_col_type   coef,
   output c2d_pkg::pix_col_type    col_out,
   output c2d_pkg::csum_type       csum
);
   import c2d_pkg::*;

   pix_col_type             win_ff;
   logic signed [PROD_W-1:0] prod_ff [3];
   csum_type                csum_ff;

   // The cell holds one window column and hands it to its left neighbor
   // whenever a new column enters.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctrl.shift) begin
         win_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= $signed(win_ff[k]) * $signed(coef[k]);
         end
         csum_ff <= CSUM_W'(prod_ff[0]) + CSUM_W'(prod_ff[1]) + CSUM_W'(prod_ff[2]);
      end
   end

   assign col_out = win_ff;
   assign csum    = csum_ff;

endmodule

`default_nettype wire
